[hw/rtl/lfbt_pkg.sv]
// Package for the login failure backoff throttle: sizes, request and
// status codes, and the structs shared by the register block, controller
// and datapath. Depends on nothing.
`default_nettype none

package lfbt_pkg;

  localparam int ACCOUNTS  = 8;
  localparam int TIME_BITS = 48;

  localparam int ACC_IDX_W = (ACCOUNTS > 1) ? $clog2(ACCOUNTS) : 1;

  localparam int CFG_ADDR_W = 5;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_FREE_TRIES = 3'd0;
  localparam logic [2:0] REG_LOCK_TRIES = 3'd1;
  localparam logic [2:0] REG_BASE_DELAY = 3'd2;
  localparam logic [2:0] REG_MAX_DELAY  = 3'd3;
  localparam logic [2:0] REG_LOCKOUT    = 3'd4;

  localparam logic [7:0]  FREE_TRIES_RST = 8'd3;
  localparam logic [7:0]  LOCK_TRIES_RST = 8'd10;
  localparam logic [31:0] BASE_DELAY_RST = 32'd1000;
  localparam logic [31:0] MAX_DELAY_RST  = 32'd60000;
  localparam logic [31:0] LOCKOUT_RST    = 32'd900000;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    REQ_CHECK   = 2'd0,
    REQ_FAIL    = 2'd1,
    REQ_SUCCESS = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [7:0]  free_tries;
    logic [7:0]  lock_tries;
    logic [31:0] base_delay_ms;
    logic [31:0] max_delay_ms;
    logic [31:0] lockout_ms;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic iter_step;
    logic iter_fin;
    logic write;
    logic out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic escalate;
    logic iter_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/lfbt_req_if.sv]
// Request channel of the login failure backoff throttle.
// Depends on nothing.
`default_nettype none

interface lfbt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  account;
  logic [47:0] now_ms;

  modport source (output valid, output req_type, output account, output now_ms,
                  input ready);
  modport sink (input valid, input req_type, input account, input now_ms,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/lfbt_rsp_if.sv]
// Response channel of the login failure backoff throttle.
// Depends on nothing.
`default_nettype none

interface lfbt_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        locked;
  logic [31:0] retry_after_ms;
  logic [7:0]  fail_count;

  modport source (output valid, output status, output locked, output retry_after_ms,
                  output fail_count, input ready);
  modport sink (input valid, input status, input locked, input retry_after_ms,
                input fail_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/lfbt_regs.sv]
// Configuration registers behind the APB-style port.
// Depends on lfbt_pkg.
`default_nettype none

module lfbt_regs (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [lfbt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output lfbt_pkg::cfg_t                   cfg_o
);

  lfbt_pkg::cfg_t cfg_q;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[lfbt_pkg::CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.free_tries    <= lfbt_pkg::FREE_TRIES_RST;
      cfg_q.lock_tries    <= lfbt_pkg::LOCK_TRIES_RST;
      cfg_q.base_delay_ms <= lfbt_pkg::BASE_DELAY_RST;
      cfg_q.max_delay_ms  <= lfbt_pkg::MAX_DELAY_RST;
      cfg_q.lockout_ms    <= lfbt_pkg::LOCKOUT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lfbt_pkg::REG_FREE_TRIES: cfg_q.free_tries    <= pwdata[7:0];
        lfbt_pkg::REG_LOCK_TRIES: cfg_q.lock_tries    <= pwdata[7:0];
        lfbt_pkg::REG_BASE_DELAY: cfg_q.base_delay_ms <= pwdata;
        lfbt_pkg::REG_MAX_DELAY:  cfg_q.max_delay_ms  <= pwdata;
        lfbt_pkg::REG_LOCKOUT:    cfg_q.lockout_ms    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lfbt_pkg::REG_FREE_TRIES: prdata = {24'd0, cfg_q.free_tries};
      lfbt_pkg::REG_LOCK_TRIES: prdata = {24'd0, cfg_q.lock_tries};
      lfbt_pkg::REG_BASE_DELAY: prdata = cfg_q.base_delay_ms;
      lfbt_pkg::REG_MAX_DELAY:  prdata = cfg_q.max_delay_ms;
      lfbt_pkg::REG_LOCKOUT:    prdata = cfg_q.lockout_ms;
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/lfbt_ctrl.sv]
// Sequencing state machine of the throttle: accepts a request, steps the
// datapath through evaluate, backoff doubling, write-back and response.
// Depends on lfbt_pkg.
`default_nettype none

module lfbt_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  lfbt_pkg::sts_t       sts_i,
  output lfbt_pkg::cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_ITER  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.escalate ? S_ITER : S_WRITE;
      end
      S_ITER: begin
        if (sts_i.iter_done) begin
          cmd_o.iter_fin = 1'b1;
          state_d        = S_WRITE;
        end else begin
          cmd_o.iter_step = 1'b1;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/lfbt_datapath.sv]
// Datapath of the throttle: account tables, request latch, backoff
// doubling unit, lock-until adder and the response register.
// Depends on lfbt_pkg.
`default_nettype none

module lfbt_datapath (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  lfbt_pkg::cmd_t       cmd_i,
  output lfbt_pkg::sts_t       sts_o,
  input  lfbt_pkg::cfg_t       cfg_i,
  input  wire  [1:0]           in_req_type_i,
  input  wire  [2:0]           in_account_i,
  input  wire  [47:0]          in_now_ms_i,
  input  wire                  out_ready_i,
  output logic                 out_valid_o,
  output logic                 out_status_o,
  output logic                 out_locked_o,
  output logic [31:0]          out_retry_after_ms_o,
  output logic [7:0]           out_fail_count_o
);

  localparam int TB = lfbt_pkg::TIME_BITS;
  localparam int IW = lfbt_pkg::ACC_IDX_W;

  logic [7:0]    cnt_q   [lfbt_pkg::ACCOUNTS];
  logic [TB-1:0] until_q [lfbt_pkg::ACCOUNTS];

  lfbt_pkg::req_type_e req_q;
  logic [IW-1:0]       idx_q;
  logic                oor_q;
  logic [TB-1:0]       now_q;
  logic [31:0]         ms_q;
  logic [8:0]          k_q;
  logic                out_valid_q;

  logic [7:0]    cur_cnt;
  logic [7:0]    new_cnt;
  logic          is_fail;
  logic          lock_hit;
  logic          free_hit;
  logic          k_lt;
  logic          ms_ge_half;
  logic [31:0]   ms_capped;
  logic [TB:0]   sum;
  logic [TB-1:0] sum_sat;
  logic [TB-1:0] cur_until;
  logic [TB-1:0] diff;
  logic          rsp_locked;
  logic [31:0]   rsp_retry;
  logic          rsp_zero;

  assign cur_cnt  = cnt_q[idx_q];
  assign new_cnt  = (cur_cnt == 8'hFF) ? cur_cnt : cur_cnt + 8'd1;
  assign is_fail  = (req_q == lfbt_pkg::REQ_FAIL) && !oor_q;
  // The lockout test takes priority over the free-try test.
  assign lock_hit = new_cnt >= cfg_i.lock_tries;
  assign free_hit = new_cnt <= cfg_i.free_tries;

  // One doubling per cycle; cur_cnt already holds the updated count here.
  assign k_lt       = k_q < {1'b0, cur_cnt};
  assign ms_ge_half = ms_q >= (cfg_i.max_delay_ms >> 1);
  assign ms_capped  = (ms_q > cfg_i.max_delay_ms) ? cfg_i.max_delay_ms : ms_q;

  assign sts_o.escalate  = is_fail && !lock_hit && !free_hit;
  assign sts_o.iter_done = !k_lt || ms_ge_half || (ms_q == 32'd0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign sum     = {1'b0, now_q} + (TB+1)'(ms_q);
  assign sum_sat = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];

  assign cur_until  = until_q[idx_q];
  assign diff       = cur_until - now_q;
  assign rsp_zero   = oor_q || (req_q == lfbt_pkg::REQ_CLEAR);
  assign rsp_locked = !rsp_zero && (cur_until > now_q);
  assign rsp_retry  = !rsp_locked ? 32'd0 :
                      (|diff[TB-1:32]) ? 32'hFFFF_FFFF : diff[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= lfbt_pkg::req_type_e'(in_req_type_i);
      idx_q <= IW'(in_account_i);
      oor_q <= {29'd0, in_account_i} >= 32'(lfbt_pkg::ACCOUNTS);
      now_q <= TB'(in_now_ms_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      ms_q <= lock_hit ? cfg_i.lockout_ms :
              free_hit ? 32'd0 : cfg_i.base_delay_ms;
      k_q  <= {1'b0, cfg_i.free_tries} + 9'd1;
    end else if (cmd_i.iter_step) begin
      ms_q <= ms_q << 1;
      k_q  <= k_q + 9'd1;
    end else if (cmd_i.iter_fin) begin
      ms_q <= (k_lt && ms_ge_half) ? cfg_i.max_delay_ms : ms_capped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lfbt_pkg::ACCOUNTS; i++) begin
        cnt_q[i]   <= 8'd0;
        until_q[i] <= '0;
      end
    end else if (cmd_i.eval) begin
      if (req_q == lfbt_pkg::REQ_CLEAR) begin
        for (int i = 0; i < lfbt_pkg::ACCOUNTS; i++) begin
          cnt_q[i]   <= 8'd0;
          until_q[i] <= '0;
        end
      end else if (!oor_q) begin
        if (req_q == lfbt_pkg::REQ_SUCCESS) begin
          cnt_q[idx_q]   <= 8'd0;
          until_q[idx_q] <= '0;
        end else if (req_q == lfbt_pkg::REQ_FAIL) begin
          cnt_q[idx_q] <= new_cnt;
        end
      end
    end else if (cmd_i.write && is_fail && (ms_q != 32'd0)) begin
      until_q[idx_q] <= sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_o         <= oor_q && (req_q != lfbt_pkg::REQ_CLEAR) ?
                              lfbt_pkg::STATUS_RANGE : lfbt_pkg::STATUS_DONE;
      out_locked_o         <= rsp_locked;
      out_retry_after_ms_o <= rsp_retry;
      out_fail_count_o     <= rsp_zero ? 8'd0 : cur_cnt;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/login_failure_backoff_throttle_top.sv]
// Top level of the login failure backoff throttle: channels, APB-style
// configuration port, controller and datapath. Depends on lfbt_pkg,
// lfbt_req_if, lfbt_rsp_if, lfbt_regs, lfbt_ctrl and lfbt_datapath.
`default_nettype none

// Per-account failed-login throttle. Each request beat names an account and
// the current time in milliseconds and returns exactly one response beat
// with the status, whether the account is locked, the remaining wait
// (saturated to 32 bits) and the failure count. A failed attempt bumps the
// saturating count and arms either the fixed lockout, nothing, or the base
// delay, doubled per failure after the first escalating one, capped at the
// maximum; a success clears the account and clear-all clears every account.
// The block handles one request at a time. A check, success, clear-all,
// out-of-range request, or a failure that arms the lockout or no delay
// passes through the evaluate, write-back and response states before the
// next request can be accepted. A failure in the escalating range also
// steps the delay through the shared shift-and-compare unit one doubling at
// a time and a final capping step; the delay reaches the cap within 31
// doublings and a zero base ends at once. The response sits in an output
// register, so a new request is taken while the previous response still
// waits; the response is loaded only once that register is free.
// Configuration registers (free_tries, lock_tries, base_delay_ms,
// max_delay_ms, lockout_ms) sit at byte addresses 0, 4, 8, 12 and 16 and
// should be written only while the block is idle.

module login_failure_backoff_throttle_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  lfbt_req_if.sink                         req,
  lfbt_rsp_if.source                       rsp,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [lfbt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  lfbt_pkg::cfg_t cfg;
  lfbt_pkg::cmd_t cmd;
  lfbt_pkg::sts_t sts;
  logic           in_ready;

  lfbt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The controller only ever talks to the datapath through cmd and sts.
  lfbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign req.ready = in_ready;

  lfbt_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_i                (cfg),
    .in_req_type_i        (req.req_type),
    .in_account_i         (req.account),
    .in_now_ms_i          (req.now_ms),
    .out_ready_i          (rsp.ready),
    .out_valid_o          (rsp.valid),
    .out_status_o         (rsp.status),
    .out_locked_o         (rsp.locked),
    .out_retry_after_ms_o (rsp.retry_after_ms),
    .out_fail_count_o     (rsp.fail_count)
  );

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for login_failure_backoff_throttle_top: a directed stimulus table,
// then random request traffic with random stalls, every response beat checked against a predictor.
// Depends on lfbt_pkg, lfbt_req_if, lfbt_rsp_if and the RTL of the throttle.
module testbench;
  import lfbt_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam logic [TIME_BITS-1:0] MAX_NOW = '1;

  // One response beat as the predictor sees it.
  typedef struct packed {
    logic        status;
    logic        locked;
    logic [31:0] retry_after_ms;
    logic [7:0]  fail_count;
  } verdict_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_e;

  // One row of the directed table: either a request beat or a full set of
  // register values that is applied once the block has gone idle.
  typedef struct {
    row_kind_e            kind;
    req_type_e            op;
    logic [2:0]           acct;
    logic [TIME_BITS-1:0] now;
    logic                 pinned;
    verdict_t             want;
    cfg_t                 cfg;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  lfbt_req_if req_if ();
  lfbt_rsp_if rsp_if ();

  login_failure_backoff_throttle_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the register file and of the per-account tables.
  cfg_t                 shadow_cfg;
  logic [7:0]           fail_tbl  [ACCOUNTS];
  logic [TIME_BITS-1:0] until_tbl [ACCOUNTS];

  // Responses still owed by the block, oldest first.
  verdict_t pending_verdicts[$];
  stim_row_t directed_rows[$];

  // A directed row with a typed-in answer travels alongside its request beat,
  // so the request monitor can queue that answer instead of the predicted one.
  logic     pin_valid;
  verdict_t pin_want;

  int unsigned          errors;
  int unsigned          burst_left;
  bit                   hold_off_req;
  logic [TIME_BITS-1:0] clock_ms;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void wipe_accounts();
    int i;
    for (i = 0; i < ACCOUNTS; i++) begin
      fail_tbl[i]  = '0;
      until_tbl[i] = '0;
    end
  endfunction

  // Delay armed by a failure that brings the count to fails. The lockout test
  // comes first, so a lock threshold at or below the free tries still locks.
  // The doubling stops at the cap before it could overflow 32 bits.
  function automatic logic [31:0] armed_delay(input logic [7:0] fails);
    logic [31:0] ms;
    int unsigned k;
    if (fails >= shadow_cfg.lock_tries) return shadow_cfg.lockout_ms;
    if (fails <= shadow_cfg.free_tries) return '0;
    ms = shadow_cfg.base_delay_ms;
    for (k = 32'(shadow_cfg.free_tries) + 1; k < 32'(fails); k++) begin
      if (ms >= shadow_cfg.max_delay_ms / 2) return shadow_cfg.max_delay_ms;
      ms = ms * 2;
    end
    return (ms > shadow_cfg.max_delay_ms) ? shadow_cfg.max_delay_ms : ms;
  endfunction

  // Applies one request to the shadow tables and returns the response beat.
  function automatic verdict_t predict_throttle(input req_type_e op, input logic [2:0] acct,
                                                input logic [TIME_BITS-1:0] now);
    verdict_t             v;
    logic [31:0]          d;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] remaining;
    v = '0;
    if (op == REQ_CLEAR) begin
      wipe_accounts();
      return v;
    end
    if (int'(acct) >= ACCOUNTS) begin
      v.status = STATUS_RANGE;
      return v;
    end
    if (op == REQ_FAIL) begin
      if (fail_tbl[acct] != 8'hFF) fail_tbl[acct] = fail_tbl[acct] + 8'd1;
      d = armed_delay(fail_tbl[acct]);
      // A zero delay leaves the lock-until time alone; a sum past the top of
      // the time range pins the lock-until time at the top.
      if (d != 0) begin
        sum = {1'b0, now} + {{(TIME_BITS - 31){1'b0}}, d};
        until_tbl[acct] = sum[TIME_BITS] ? MAX_NOW : sum[TIME_BITS-1:0];
      end
    end else if (op == REQ_SUCCESS) begin
      fail_tbl[acct]  = '0;
      until_tbl[acct] = '0;
    end
    if (until_tbl[acct] > now) begin
      remaining = until_tbl[acct] - now;
      v.locked = 1'b1;
      v.retry_after_ms = (remaining > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : remaining[31:0];
    end
    v.status     = STATUS_DONE;
    v.fail_count = fail_tbl[acct];
    return v;
  endfunction

  function automatic verdict_t verdict(input logic locked, input logic [31:0] retry,
                                       input logic [7:0] count);
    verdict_t v;
    v.status         = STATUS_DONE;
    v.locked         = locked;
    v.retry_after_ms = retry;
    v.fail_count     = count;
    return v;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  // Every accepted request beat is predicted at the edge that accepts it.
  always @(posedge clk_i) begin : request_monitor
    verdict_t v;
    if (rst_ni && req_if.valid && req_if.ready) begin
      v = predict_throttle(req_type_e'(req_if.req_type), req_if.account, req_if.now_ms);
      if (pin_valid) v = pin_want;
      pending_verdicts.push_back(v);
    end
  end

  // Every accepted response beat is compared with the oldest owed response.
  always @(posedge clk_i) begin : response_monitor
    verdict_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: response beat with none owed, expected nothing, actual %0h/%0h/%0h/%0h",
                 $time, rsp_if.status, rsp_if.locked, rsp_if.retry_after_ms,
                 rsp_if.fail_count);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_if.status));
        check_field("locked", 32'(want.locked), 32'(rsp_if.locked));
        check_field("retry_after_ms", want.retry_after_ms, rsp_if.retry_after_ms);
        check_field("fail_count", 32'(want.fail_count), 32'(rsp_if.fail_count));
      end
    end
  end

  // The receiver switches between stall patterns of random length: always
  // ready, a coin toss, mostly stalled, and a fixed two-in-three rhythm. When
  // the stimulus asks for it, it refuses every beat for a long stretch, so the
  // output register and the request in flight back up into the request side.
  initial begin : response_stalls
    int unsigned mode;
    int unsigned left;
    int unsigned held;
    rsp_if.ready <= 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        rsp_if.ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0: begin
            rsp_if.ready <= 1'b1;
          end
          1: begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            rsp_if.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            rsp_if.ready <= (left % 3 != 0);
          end
        endcase
      end
    end
  end

  // A hung block ends the run here.
  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk_i);
    $display("%0t: cycle limit reached with %0d responses owed", $time,
             pending_verdicts.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // One register write followed by a read-back of the same register. Only
  // the low byte of the count registers is kept, so the read must show it.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] kept;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    kept = value;
    case (idx)
      REG_FREE_TRIES: begin
        kept = {24'd0, value[7:0]};
        shadow_cfg.free_tries = value[7:0];
      end
      REG_LOCK_TRIES: begin
        kept = {24'd0, value[7:0]};
        shadow_cfg.lock_tries = value[7:0];
      end
      REG_BASE_DELAY: begin
        shadow_cfg.base_delay_ms = value;
      end
      REG_MAX_DELAY: begin
        shadow_cfg.max_delay_ms = value;
      end
      default: begin
        shadow_cfg.lockout_ms = value;
      end
    endcase
    check_field("register read-back", kept, prdata);
  endtask

  // Writes all five registers; the count registers get random upper bits.
  task automatic apply_config(input logic [7:0] free_tries, input logic [7:0] lock_tries,
                              input logic [31:0] base_ms, input logic [31:0] max_ms,
                              input logic [31:0] lock_ms);
    logic [31:0] noise;
    noise = $urandom;
    write_reg(REG_FREE_TRIES, {noise[31:8], free_tries});
    write_reg(REG_LOCK_TRIES, {noise[23:0], lock_tries});
    write_reg(REG_BASE_DELAY, base_ms);
    write_reg(REG_MAX_DELAY, max_ms);
    write_reg(REG_LOCKOUT, lock_ms);
  endtask

  // Stops offering and waits until every owed response has been taken.
  task automatic drain();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Offers one request beat and returns at the edge that accepts it. The
  // sender works in bursts of random length with random gaps in between;
  // a gap of zero lets two bursts run together.
  task automatic offer(input req_type_e op, input logic [2:0] acct,
                       input logic [TIME_BITS-1:0] now, input logic pinned,
                       input verdict_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.account  <= acct;
    req_if.now_ms   <= now;
    pin_valid       <= pinned;
    pin_want        <= want;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic void add_row(input req_type_e op, input logic [2:0] acct,
                                  input logic [TIME_BITS-1:0] now, input logic pinned,
                                  input verdict_t want);
    stim_row_t r;
    r.kind   = ROW_REQ;
    r.op     = op;
    r.acct   = acct;
    r.now    = now;
    r.pinned = pinned;
    r.want   = want;
    r.cfg    = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [7:0] free_tries, input logic [7:0] lock_tries,
                                  input logic [31:0] base_ms, input logic [31:0] max_ms,
                                  input logic [31:0] lock_ms);
    stim_row_t r;
    r.kind   = ROW_CFG;
    r.op     = REQ_CHECK;
    r.acct   = '0;
    r.now    = '0;
    r.pinned = 1'b0;
    r.want   = '0;
    r.cfg    = {free_tries, lock_tries, base_ms, max_ms, lock_ms};
    directed_rows.push_back(r);
  endfunction

  // Random traffic. Failures cluster on a few accounts so that counts climb
  // into the escalating range; time mostly moves forward in small steps, with
  // now and then a jump to an arbitrary time or to the top of the range. In
  // the hammer form almost every beat is a failure on one account, which
  // drives its count to saturation, and the rest are checks.
  task automatic random_items(input int n, input int hold_at, input int pause_at,
                              input bit hammer);
    logic [2:0]           focus;
    logic [2:0]           acct;
    req_type_e            op;
    logic [63:0]          wide;
    logic [TIME_BITS-1:0] now;
    int                   roll;
    int                   i;
    focus = 3'($urandom_range(0, 7));
    for (i = 0; i < n; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      if (i == pause_at) drain();
      roll = $urandom_range(0, 99);
      if (hammer) op = (roll < 90) ? REQ_FAIL : REQ_CHECK;
      else if (roll < 50) op = REQ_FAIL;
      else if (roll < 78) op = REQ_CHECK;
      else if (roll < 95) op = REQ_SUCCESS;
      else op = REQ_CLEAR;
      if (hammer && op == REQ_FAIL) acct = focus;
      else if ($urandom_range(0, 99) < 60) acct = 3'($urandom_range(0, 2));
      else acct = 3'($urandom_range(0, 7));
      roll = $urandom_range(0, 19);
      wide = {$urandom, $urandom};
      if (roll == 0) begin
        now = wide[TIME_BITS-1:0];
      end else if (roll == 1) begin
        now = MAX_NOW - $urandom_range(0, 100000);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, 4000);
        now = clock_ms;
      end
      offer(op, acct, now, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [7:0] free_pick;
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_CHECK;
    req_if.account  <= '0;
    req_if.now_ms   <= '0;
    pin_valid       <= 1'b0;
    pin_want        <= '0;
    errors       = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    clock_ms     = '0;
    shadow_cfg   = {FREE_TRIES_RST, LOCK_TRIES_RST, BASE_DELAY_RST, MAX_DELAY_RST, LOCKOUT_RST};
    wipe_accounts();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, under the reset register values at first. Answers are
    // typed in where they are plain: the empty tables after reset, the free
    // tries, the first escalating delay, a success, a clear-all, and the
    // saturation cases. The rest is left to the predictor.
    add_row(REQ_CHECK,   3'd0, '0,      1'b1, verdict(1'b0, 32'd0, 8'd0));
    add_row(REQ_CHECK,   3'd5, MAX_NOW, 1'b1, verdict(1'b0, 32'd0, 8'd0));
    add_row(REQ_FAIL,    3'd7, 48'd100, 1'b1, verdict(1'b0, 32'd0, 8'd1));
    add_row(REQ_FAIL,    3'd7, 48'd200, 1'b1, verdict(1'b0, 32'd0, 8'd2));
    add_row(REQ_FAIL,    3'd7, 48'd300, 1'b1, verdict(1'b0, 32'd0, 8'd3));
    add_row(REQ_FAIL,    3'd7, 48'd1000, 1'b1, verdict(1'b1, 32'd1000, 8'd4));
    add_row(REQ_FAIL,    3'd7, 48'd1500, 1'b0, '0);
    add_row(REQ_CHECK,   3'd7, 48'd2000, 1'b0, '0);
    add_row(REQ_SUCCESS, 3'd7, 48'd2100, 1'b1, verdict(1'b0, 32'd0, 8'd0));
    add_row(REQ_FAIL,    3'd1, '0,      1'b1, verdict(1'b0, 32'd0, 8'd1));
    add_row(REQ_CLEAR,   3'd6, 48'd7,   1'b1, verdict(1'b0, 32'd0, 8'd0));
    add_row(REQ_CHECK,   3'd1, 48'd8,   1'b1, verdict(1'b0, 32'd0, 8'd0));
    // No free tries and the widest delay: the lock-until time runs past the
    // top of the time range, and seen from time zero the wait exceeds 32 bits.
    add_cfg(8'd0, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    add_row(REQ_FAIL,    3'd2, MAX_NOW - 15, 1'b1, verdict(1'b1, 32'd15, 8'd1));
    add_row(REQ_CHECK,   3'd2, '0,      1'b1, verdict(1'b1, 32'hFFFF_FFFF, 8'd1));
    add_row(REQ_FAIL,    3'd2, 48'd1,   1'b0, '0);
    // Lock threshold below the free tries: the very first failure locks.
    add_cfg(8'd255, 8'd1, 32'd0, 32'd0, 32'd5000);
    add_row(REQ_FAIL,    3'd3, 48'd10,  1'b1, verdict(1'b1, 32'd5000, 8'd1));
    add_row(REQ_CHECK,   3'd3, 48'd5010, 1'b1, verdict(1'b0, 32'd0, 8'd1));
    // Base above the cap: the first escalating delay is the cap itself.
    add_cfg(8'd1, 8'd200, 32'd50000, 32'd3000, 32'd0);
    add_row(REQ_FAIL,    3'd4, '0,      1'b0, '0);
    add_row(REQ_FAIL,    3'd4, '0,      1'b1, verdict(1'b1, 32'd3000, 8'd2));
    // A zero base arms nothing, so the earlier lock stays in force.
    add_cfg(8'd1, 8'd200, 32'd0, 32'd100, 32'd0);
    add_row(REQ_FAIL,    3'd4, 48'd10,  1'b0, '0);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        drain();
        apply_config(directed_rows[r].cfg.free_tries, directed_rows[r].cfg.lock_tries,
                     directed_rows[r].cfg.base_delay_ms, directed_rows[r].cfg.max_delay_ms,
                     directed_rows[r].cfg.lockout_ms);
      end else begin
        offer(directed_rows[r].op, directed_rows[r].acct, directed_rows[r].now,
              directed_rows[r].pinned, directed_rows[r].want);
      end
    end

    // Reset values again. Early on the receiver holds off for a long stretch
    // while the sender keeps offering; later the sender pauses until every
    // owed response is back.
    drain();
    apply_config(FREE_TRIES_RST, LOCK_TRIES_RST, BASE_DELAY_RST, MAX_DELAY_RST, LOCKOUT_RST);
    random_items(150, 40, 100, 1'b0);

    // Count saturation with an uncapped delay and a zero lockout.
    drain();
    apply_config(8'($urandom_range(0, 5)), 8'd255, $urandom_range(1, 100), 32'hFFFF_FFFF,
                 32'd0);
    random_items(300, -1, -1, 1'b1);

    // Fully random register values.
    drain();
    apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)), $urandom, $urandom,
                 $urandom);
    random_items(120, -1, -1, 1'b0);

    // Opposite extremes: nothing escalates, a zero cap, the longest lockout.
    drain();
    apply_config(8'd255, 8'd255, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    random_items(100, -1, -1, 1'b0);

    // Small thresholds, so all three kinds of failure show up often.
    drain();
    free_pick = 8'($urandom_range(0, 4));
    apply_config(free_pick, free_pick + 8'($urandom_range(1, 8)), $urandom_range(1, 2000),
                 $urandom_range(0, 100000), $urandom_range(0, 200000));
    random_items(120, -1, -1, 1'b0);

    drain();
    repeat (40) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d owed responses never arrived", $time, pending_verdicts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
